>>> design/horizontal_correlation_cost_volume_defines.svh
// ----------------------------------------------------------------------------
// Correlation cost volume assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HORIZONTAL_CORRELATION_COST_VOLUME_DEFINES_SVH
`define HORIZONTAL_CORRELATION_COST_VOLUME_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HCCV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HCCV_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define HCCV_ASSERT(lbl, prop, msg)
`define HCCV_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> design/hccv_pkg.sv
// ----------------------------------------------------------------------------
// Correlation cost volume package
// Sizes, register indexes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package hccv_pkg;

	localparam int MAX_WIDTH         = 256;
	localparam int MAX_DISPLACEMENTS = 16;

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DISP_W = (MAX_DISPLACEMENTS > 1) ? $clog2(MAX_DISPLACEMENTS) : 1;
	localparam int ADDR_W = DISP_W + COL_W;
	localparam int ACC_W  = 16;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT      = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_COUNT          = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW_WIDTH          = 3'd2;
	localparam logic [IDX_W-1:0] REG_DISPLACEMENT_COUNT = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUTPUT_SHIFT       = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC
	} state_t;

	typedef struct packed {
		logic signed [7:0] first;
		logic signed [7:0] second;
		logic [ACC_W-1:0]  base;
		logic              load;
	} mac_in_t;

endpackage

>>> design/horizontal_correlation_cost_volume.sv
// ----------------------------------------------------------------------------
// Horizontal correlation cost volume
// 1-D correlation of two signed 8-bit feature maps over horizontal shifts,
// one multiply-accumulate per read/update state pair into an accumulator RAM.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    first_value, second_value
//  out      source     out_valid / out_ready  value, displacement, row, column, last
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  An input pair is worked for n = min(column + 1, displacements) shifts:
//  one MAC unit does one displacement per read/update state pair, paced by
//  the registered read of the accumulator RAM.
//  A stalled output holds the sequencer at the next result; the last result
//  sits in the output register while the next pair transfers.
//  Reset clears counters and sequencer and sets config to its defaults; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`include "horizontal_correlation_cost_volume_defines.svh"

module horizontal_correlation_cost_volume import hccv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [7:0] first_value,
	input  logic signed [7:0] second_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] value,
	output logic [3:0]        displacement,
	output logic [15:0]       row,
	output logic [7:0]        column,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [15:0]       cfg_data
);

	logic [15:0] channel_count_q;
	logic [15:0] row_count_q;
	logic [8:0]  row_width_q;
	logic [4:0]  displacement_count_q;
	logic [3:0]  output_shift_q;

	logic [COL_W:0]  width_eff;
	logic [DISP_W:0] disp_eff;
	logic [15:0]     chans_eff;
	logic [15:0]     rows_eff;

	state_t state_q, state_d;

	logic [COL_W-1:0]  col_q;
	logic [15:0]       chan_q;
	logic [15:0]       rowc_q;
	logic [7:0]        hist_q [MAX_DISPLACEMENTS];

	logic [COL_W-1:0]  x_q;
	logic [DISP_W-1:0] d_q;
	logic signed [7:0] first_q;
	logic              first_chan_q;
	logic              last_chan_q;
	logic [15:0]       row_q;

	logic              out_valid_q;
	logic [ACC_W-1:0]  out_acc_q;
	logic [3:0]        out_disp_q;
	logic [15:0]       out_row_q;
	logic [7:0]        out_col_q;
	logic              out_last_q;

	logic              in_xfer;
	logic              last_chan;
	logic              last_d;
	logic              stall;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] addr;
	logic [ACC_W-1:0]  rd_data;
	logic [ACC_W-1:0]  acc;
	mac_in_t           mac_op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q      <= 16'd1;
			row_count_q          <= 16'd1;
			row_width_q          <= 9'd1;
			displacement_count_q <= 5'd1;
			output_shift_q       <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT:      channel_count_q      <= cfg_data;
				REG_ROW_COUNT:          row_count_q          <= cfg_data;
				REG_ROW_WIDTH:          row_width_q          <= cfg_data[8:0];
				REG_DISPLACEMENT_COUNT: displacement_count_q <= cfg_data[4:0];
				REG_OUTPUT_SHIFT:       output_shift_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		chans_eff = (channel_count_q == '0) ? 16'd1 : channel_count_q;
		rows_eff  = (row_count_q == '0) ? 16'd1 : row_count_q;
		if (row_width_q == '0) begin
			width_eff = (COL_W+1)'(1);
		end else if (int'(row_width_q) > MAX_WIDTH) begin
			width_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			width_eff = (COL_W+1)'(row_width_q);
		end
		if (displacement_count_q == '0) begin
			disp_eff = (DISP_W+1)'(1);
		end else if (int'(displacement_count_q) > MAX_DISPLACEMENTS) begin
			disp_eff = (DISP_W+1)'(MAX_DISPLACEMENTS);
		end else begin
			disp_eff = (DISP_W+1)'(displacement_count_q);
		end
	end

	assign in_xfer   = in_valid && in_ready;
	assign last_chan = ({1'b0, chan_q} + 17'd1) >= {1'b0, chans_eff};
	assign last_d    = (COL_W'(d_q) == x_q) || (({1'b0, d_q} + 1'b1) == disp_eff);
	assign stall     = last_chan_q && out_valid_q && !out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_READ;
			ST_READ: state_d = ST_MAC;
			ST_MAC: begin
				if (!stall) begin
					state_d = last_d ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_READ: rd_en    = 1'b1;
			ST_MAC:  wr_en    = !stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// position counters advance on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			chan_q <= '0;
			rowc_q <= '0;
		end else if (in_xfer) begin
			if (({1'b0, col_q} + 1'b1) >= width_eff) begin
				col_q <= '0;
				if (last_chan) begin
					chan_q <= '0;
					if (({1'b0, rowc_q} + 17'd1) >= {1'b0, rows_eff}) begin
						rowc_q <= '0;
					end else begin
						rowc_q <= rowc_q + 16'd1;
					end
				end else begin
					chan_q <= chan_q + 16'd1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// item context; history shifts at transfer so entry d is the partner of d
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q          <= col_q;
			first_q      <= first_value;
			first_chan_q <= (chan_q == '0);
			last_chan_q  <= last_chan;
			row_q        <= rowc_q;
			hist_q[0]    <= second_value;
			for (int i = 1; i < MAX_DISPLACEMENTS; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (in_xfer) begin
			d_q <= '0;
		end else if (wr_en && !last_d) begin
			d_q <= d_q + 1'b1;
		end
	end

	assign addr = {d_q, x_q};

	hccv_acc_ram #(
		.ADDR_W(ADDR_W),
		.DATA_W(ACC_W)
	) u_acc_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (acc),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_comb begin
		mac_op.first  = first_q;
		mac_op.second = $signed(hist_q[d_q]);
		mac_op.base   = rd_data;
		mac_op.load   = first_chan_q;
	end

	hccv_mac u_mac (
		.op       (mac_op),
		.res_acc  (out_acc_q),
		.shift    (output_shift_q),
		.acc      (acc),
		.narrowed (value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && last_chan_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && last_chan_q) begin
			out_acc_q  <= acc;
			out_disp_q <= 4'(d_q);
			out_row_q  <= row_q;
			out_col_q  <= 8'(x_q);
			out_last_q <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign displacement = out_disp_q;
	assign row          = out_row_q;
	assign column       = out_col_q;
	assign last         = out_last_q;

	`HCCV_ASSERT(a_disp_le_col, !out_valid || (8'(displacement) <= column), "displacement beyond column")
	`HCCV_ASSERT(a_d_in_range, (state_q != ST_MAC) || (({1'b0, d_q}) < disp_eff), "displacement index out of range")
	`HCCV_ASSERT_NEXT(a_stall_holds, (state_q == ST_MAC) && stall, state_q == ST_MAC, "result dropped under stall")
	`HCCV_ASSERT_NEXT(a_xfer_reads, in_xfer, (state_q == ST_READ) && (d_q == '0), "transfer did not start a read")

endmodule

>>> design/hccv_acc_ram.sv
// ----------------------------------------------------------------------------
// Accumulator RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module hccv_acc_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/hccv_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// 8x8 signed product added to a wrapping 16-bit accumulator, plus the
// arithmetic shift and truncation applied to a registered result.
// ----------------------------------------------------------------------------
module hccv_mac import hccv_pkg::*; (
	input  mac_in_t           op,
	input  logic [ACC_W-1:0]  res_acc,
	input  logic [3:0]        shift,
	output logic [ACC_W-1:0]  acc,
	output logic signed [7:0] narrowed
);

	logic signed [ACC_W-1:0] prod;
	logic [ACC_W-1:0]        base;
	logic signed [ACC_W-1:0] shifted;

	always_comb begin
		prod    = ACC_W'(op.first * op.second);
		base    = op.load ? '0 : op.base;
		acc     = base + prod;
		shifted = $signed(res_acc) >>> shift;
		narrowed = shifted[7:0];
	end

endmodule
